// ===== sv/ictf_pkg.sv =====
package ictf_pkg;

    localparam int MaxSteps = 24;

    localparam logic CfgAlpha = 1'b0;
    localparam logic CfgGain  = 1'b1;

    typedef struct packed {
        logic       load;
        logic       iter;
        logic [4:0] step;
        logic       gain;
        logic       pload;
        logic       sum;
        logic       mul;
        logic       finish;
    } t_cmd;

    typedef struct packed {
        logic gyro_done;
    } t_status;

    function automatic logic signed [31:0] atan_q16(logic [4:0] idx);
        logic signed [31:0] v;
        unique case (idx)
            5'd0:  v = 32'sd2949120;
            5'd1:  v = 32'sd1740967;
            5'd2:  v = 32'sd919879;
            5'd3:  v = 32'sd466945;
            5'd4:  v = 32'sd234379;
            5'd5:  v = 32'sd117304;
            5'd6:  v = 32'sd58666;
            5'd7:  v = 32'sd29335;
            5'd8:  v = 32'sd14668;
            5'd9:  v = 32'sd7334;
            5'd10: v = 32'sd3667;
            5'd11: v = 32'sd1833;
            5'd12: v = 32'sd917;
            5'd13: v = 32'sd458;
            5'd14: v = 32'sd229;
            5'd15: v = 32'sd115;
            5'd16: v = 32'sd57;
            5'd17: v = 32'sd29;
            5'd18: v = 32'sd14;
            5'd19: v = 32'sd7;
            5'd20: v = 32'sd4;
            5'd21: v = 32'sd2;
            5'd22: v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(logic signed [50:0] v);
        logic signed [31:0] r;
        if (v > 51'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -51'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== sv/ictf_ctrl.sv =====
module ictf_ctrl #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  ictf_pkg::t_status  i_status,
    output ictf_pkg::t_cmd     o_cmd
);

    localparam int Steps = (CORDIC_STEPS > ictf_pkg::MaxSteps) ? ictf_pkg::MaxSteps
                                                               : CORDIC_STEPS;
    localparam logic [4:0] LastStep = 5'(Steps - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_ROLL, S_GAIN, S_PLOAD, S_PITCH, S_WAIT, S_SUM, S_MUL, S_DONE
    } t_state;

    t_state     r_state, n_state;
    logic [4:0] r_step, n_step;
    logic       r_out_valid, n_out_valid;
    logic       w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.step  = r_step;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = S_ROLL;
                end
            end
            S_ROLL: begin
                o_cmd.iter = 1'b1;
                n_step     = r_step + 5'd1;
                if (r_step == LastStep) n_state = S_GAIN;
            end
            S_GAIN: begin
                o_cmd.gain = 1'b1;
                n_state    = S_PLOAD;
            end
            S_PLOAD: begin
                o_cmd.pload = 1'b1;
                n_step      = '0;
                n_state     = S_PITCH;
            end
            S_PITCH: begin
                o_cmd.iter = 1'b1;
                n_step     = r_step + 5'd1;
                if (r_step == LastStep) n_state = S_WAIT;
            end
            S_WAIT: begin
                if (i_status.gyro_done) n_state = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== sv/ictf_datapath.sv =====
module ictf_datapath #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ictf_pkg::t_cmd     i_cmd,
    input  logic [95:0]        i_in_data,
    input  logic               i_cfg_we,
    input  logic               i_cfg_addr,
    input  logic [23:0]        i_cfg_data,
    output ictf_pkg::t_status  o_status,
    output logic [63:0]        o_out_data
);

    localparam int Steps = (CORDIC_STEPS > ictf_pkg::MaxSteps) ? ictf_pkg::MaxSteps
                                                               : CORDIC_STEPS;
    localparam int Sh = 2 * Steps;
    localparam longint InvGain = 64'd652032874
        + ((64'd434688583 + (64'd1 << (Sh - 1))) >> Sh);
    localparam logic [29:0] InvGainQ30 = 30'(InvGain);
    localparam int DivLen = 4;
    localparam logic [2:0] DivStart = 3'(DivLen + 1);
    localparam logic [41:0] Recip = 42'd2305843009214;

    logic [15:0]        r_alpha;
    logic [23:0]        r_gain;
    logic signed [15:0] r_ax;
    logic signed [33:0] r_cx, r_cy;
    logic signed [31:0] r_cz;
    logic               r_czero;
    logic signed [31:0] r_roll_acc;
    logic [61:0]        r_prod;
    logic               r_gneg_x, r_gneg_y;
    logic [15:0]        r_dt;
    logic [39:0]        r_p1x, r_p1y;
    logic [40:0]        r_nx, r_ny;
    logic [53:0]        r_accx, r_accy;
    logic [2:0]         r_gcnt;
    logic signed [31:0] r_sum_r, r_sum_p;
    logic signed [49:0] r_ma_r, r_mb_r, r_ma_p, r_mb_p;
    logic signed [31:0] r_roll, r_pitch;
    logic               r_seeded;
    logic [63:0]        r_out;

    logic signed [15:0] w_ax, w_ay, w_az, w_gx, w_gy;
    logic signed [33:0] w_ldx, w_ldy, w_rx, w_ry;
    logic signed [31:0] w_rz;
    logic [32:0]        w_mag;
    logic signed [33:0] w_dx, w_dy;
    logic signed [31:0] w_atan;
    logic [15:0]        w_absx, w_absy;
    logic signed [31:0] w_dlt_r, w_dlt_p;
    logic [16:0]        w_na;
    logic signed [50:0] w_mix_r, w_mix_p;
    logic signed [31:0] w_new_r, w_new_p;

    function automatic logic signed [33:0] scale14(logic signed [15:0] v);
        return {{4{v[15]}}, v, 14'd0};
    endfunction

    function automatic logic [15:0] abs16(logic signed [15:0] v);
        logic signed [16:0] e;
        e = {v[15], v};
        return v[15] ? 16'(-e) : 16'(e);
    endfunction

    function automatic logic signed [31:0] signed_q(logic neg, logic [28:0] q);
        logic signed [31:0] m;
        m = {3'd0, q};
        return neg ? -m : m;
    endfunction

    assign w_ax = i_in_data[15:0];
    assign w_ay = i_in_data[31:16];
    assign w_az = i_in_data[47:32];
    assign w_gx = i_in_data[63:48];
    assign w_gy = i_in_data[79:64];

    assign w_mag = 33'((r_prod + 62'd536870912) >> 30);

    always_comb begin
        if (i_cmd.pload) begin
            w_ldx = {1'b0, w_mag};
            w_ldy = -scale14(r_ax);
        end else begin
            w_ldx = scale14(w_az);
            w_ldy = scale14(w_ay);
        end
        w_rx = w_ldx;
        w_ry = w_ldy;
        w_rz = '0;
        if (w_ldx < 0) begin
            if (w_ldy >= 0) begin
                w_rx = w_ldy;
                w_ry = -w_ldx;
                w_rz = 32'sd5898240;
            end else begin
                w_rx = -w_ldy;
                w_ry = w_ldx;
                w_rz = -32'sd5898240;
            end
        end
    end

    assign w_dx   = r_cy >>> i_cmd.step;
    assign w_dy   = r_cx >>> i_cmd.step;
    assign w_atan = ictf_pkg::atan_q16(i_cmd.step);

    assign w_absx = abs16(w_gx);
    assign w_absy = abs16(w_gy);

    assign w_dlt_r = signed_q(r_gneg_x, r_accx[50:22]);
    assign w_dlt_p = signed_q(r_gneg_y, r_accy[50:22]);
    assign w_na    = 17'd65536 - {1'b0, r_alpha};

    assign w_mix_r = 51'(r_ma_r) + 51'(r_mb_r) + 51'sd32768;
    assign w_mix_p = 51'(r_ma_p) + 51'(r_mb_p) + 51'sd32768;
    assign w_new_r = r_seeded ? ictf_pkg::sat32(w_mix_r >>> 16) : r_roll_acc;
    assign w_new_p = r_seeded ? ictf_pkg::sat32(w_mix_p >>> 16) : r_cz;

    assign o_status.gyro_done = (r_gcnt == '0);
    assign o_out_data         = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha  <= 16'd64225;
            r_gain   <= 24'd1023001;
            r_gcnt   <= '0;
            r_roll   <= '0;
            r_pitch  <= '0;
            r_seeded <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == ictf_pkg::CfgAlpha) r_alpha <= i_cfg_data[15:0];
                if (i_cfg_addr == ictf_pkg::CfgGain) r_gain <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_gcnt <= DivStart;
            end else if (r_gcnt != '0) begin
                r_gcnt <= r_gcnt - 3'd1;
            end
            if (i_cmd.finish) begin
                r_roll   <= w_new_r;
                r_pitch  <= w_new_p;
                r_seeded <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ax     <= w_ax;
            r_gneg_x <= w_gx[15];
            r_gneg_y <= w_gy[15];
            r_dt     <= i_in_data[95:80];
            r_p1x    <= w_absx * r_gain;
            r_p1y    <= w_absy * r_gain;
        end
        if (i_cmd.load || i_cmd.pload) begin
            r_cx    <= w_rx;
            r_cy    <= w_ry;
            r_cz    <= w_rz;
            r_czero <= (w_ldx == '0) && (w_ldy == '0);
        end else if (i_cmd.iter && !r_czero) begin
            if (r_cy >= 0) begin
                r_cx <= r_cx + w_dx;
                r_cy <= r_cy - w_dy;
                r_cz <= r_cz + w_atan;
            end else begin
                r_cx <= r_cx - w_dx;
                r_cy <= r_cy + w_dy;
                r_cz <= r_cz - w_atan;
            end
        end
        if (i_cmd.gain) begin
            r_prod     <= r_cx[31:0] * InvGainQ30;
            r_roll_acc <= r_cz;
        end
        if (!i_cmd.load && r_gcnt == DivStart) begin
            r_nx   <= 41'((57'(r_p1x * r_dt) + 57'd128000000) >> 14);
            r_ny   <= 41'((57'(r_p1y * r_dt) + 57'd128000000) >> 14);
            r_accx <= '0;
            r_accy <= '0;
        end else if (r_gcnt != '0) begin
            r_accx <= (r_accx >> 11) + 54'(r_nx[10:0] * Recip);
            r_accy <= (r_accy >> 11) + 54'(r_ny[10:0] * Recip);
            r_nx   <= r_nx >> 11;
            r_ny   <= r_ny >> 11;
        end
        if (i_cmd.sum) begin
            r_sum_r <= ictf_pkg::sat32(51'(r_roll) + 51'(w_dlt_r));
            r_sum_p <= ictf_pkg::sat32(51'(r_pitch) + 51'(w_dlt_p));
        end
        if (i_cmd.mul) begin
            r_ma_r <= signed'({1'b0, r_alpha}) * r_sum_r;
            r_mb_r <= signed'({1'b0, w_na}) * r_roll_acc;
            r_ma_p <= signed'({1'b0, r_alpha}) * r_sum_p;
            r_mb_p <= signed'({1'b0, w_na}) * r_cz;
        end
        if (i_cmd.finish) begin
            r_out <= {w_new_p, w_new_r};
        end
    end

endmodule

// ===== sv/imu_complementary_tilt_filter_core.sv =====
// Roll/pitch complementary filter for a six-axis inertial sensor.
// Input stream: one word per sample carrying raw accel x/y/z, gyro x/y and
// the microseconds elapsed since the previous sample. Output stream: one word
// per input word with filtered roll and pitch, signed Q15.16 degrees.
// Accel tilt comes from two passes of one iterative CORDIC unit (one
// rotation per cycle); the gyro step is a reciprocal multiplication done in
// four 11-bit slices while the first CORDIC pass runs.
// The delay from input accept to output valid is set by the two CORDIC
// passes (steps above 24 act as 24). One word is in flight at a time, and
// the next input can be taken in the cycle after the result is registered.
// The output register holds a finished result while the receiver stalls;
// the next result waits in the block until that register frees up.
// Reset restores blend_alpha and gyro_gain, clears the angles and arms the
// seeding of the first sample from the accel angles alone.
// Config writes are registered and are meant for idle periods only.
module imu_complementary_tilt_filter_core #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, elapsed_us
    input  logic [95:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // roll_angle, pitch_angle
    output logic [63:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [23:0] i_cfg_data
);

    ictf_pkg::t_cmd    w_cmd;
    ictf_pkg::t_status w_status;

    ictf_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    ictf_datapath #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_in_data (s_axis_tdata),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_addr(i_cfg_addr),
        .i_cfg_data(i_cfg_data),
        .o_status  (w_status),
        .o_out_data(m_axis_tdata)
    );

endmodule

// ===== sv/ictf_checker.sv =====
module ictf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a word is in flight");

    a_no_result_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result shown one cycle after accept");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind imu_complementary_tilt_filter_core ictf_checker u_ictf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);
